// ===== hw/rtl/crs_pkg.sv =====
// Shared types and constants for the child restart supervisor.
package crs_pkg;

    localparam logic [2:0] PH_NOT_STARTED = 3'd0;
    localparam logic [2:0] PH_STARTING    = 3'd1;
    localparam logic [2:0] PH_RUNNING     = 3'd2;
    localparam logic [2:0] PH_BACKOFF     = 3'd3;
    localparam logic [2:0] PH_EXITED      = 3'd4;
    localparam logic [2:0] PH_FATAL       = 3'd5;
    localparam logic [2:0] PH_STOPPING    = 3'd6;
    localparam logic [2:0] PH_STOPPED     = 3'd7;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_EXIT    = 3'd1;
    localparam logic [2:0] OP_KILL    = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    localparam logic [1:0] MODE_ALWAYS     = 2'd1;
    localparam logic [1:0] MODE_UNEXPECTED = 2'd2;

    localparam logic [2:0] REG_START_POLICY  = 3'd0;
    localparam logic [2:0] REG_START_RETRIES = 3'd1;
    localparam logic [2:0] REG_START_WAIT    = 3'd2;
    localparam logic [2:0] REG_STOP_WAIT     = 3'd3;
    localparam logic [2:0] REG_CODES_A       = 3'd4;
    localparam logic [2:0] REG_CODES_B       = 3'd5;
    localparam logic [2:0] REG_CODES_C       = 3'd6;
    localparam logic [2:0] REG_CODES_D       = 3'd7;

    typedef struct packed {
        logic [2:0] phase;
        logic       alive;
        logic [7:0] retry_count;
        logic [7:0] timer;
        logic       armed;
        logic       pending;
    } crs_state_t;

    typedef struct packed {
        logic [2:0]       start_policy;
        logic [7:0]       start_retries;
        logic [7:0]       start_wait;
        logic [7:0]       stop_wait;
        logic [3:0][63:0] codes;
    } crs_cfg_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       launch;
        logic       kill;
        logic [7:0] retries_used;
    } crs_result_t;

endpackage

// ===== hw/rtl/crs_step.sv =====
// Next-state and result logic for one supervisor item.
module crs_step
    import crs_pkg::*;
#(
    parameter int BACKOFF_DELAY = 5
) (
    input  crs_state_t  state_cur,
    input  crs_cfg_t    cfg,
    input  logic [2:0]  op,
    input  logic [7:0]  exit_code,
    output crs_state_t  state_new,
    output crs_result_t result
);

    localparam logic [7:0] BackoffDelay = 8'(BACKOFF_DELAY);

    crs_state_t ns;
    logic       launch_now;
    logic       kill_now;
    logic [1:0] mode;
    logic [7:0] bumped;
    logic       accepted;

    always_comb
    begin
        mode       = cfg.start_policy[2:1];
        bumped     = (state_cur.timer == 8'hFF) ? 8'hFF : state_cur.timer + 8'd1;
        accepted   = cfg.codes[exit_code[7:6]][exit_code[5:0]];
        ns         = state_cur;
        launch_now = 1'b0;
        kill_now   = 1'b0;
        unique case (op)
            OP_TICK:
            begin
                if ((state_cur.phase == PH_NOT_STARTED && cfg.start_policy[0]) ||
                    (state_cur.phase == PH_EXITED && mode == MODE_ALWAYS))
                begin
                    if (!state_cur.alive)
                    begin
                        ns.alive   = 1'b1;
                        ns.phase   = PH_STARTING;
                        ns.timer   = 8'd0;
                        launch_now = 1'b1;
                    end
                end
                else if (state_cur.phase == PH_STARTING)
                begin
                    ns.timer = bumped;
                    if (cfg.start_wait == 8'd0 || bumped >= cfg.start_wait)
                    begin
                        ns.phase       = PH_RUNNING;
                        ns.retry_count = 8'd0;
                    end
                end
                else if (state_cur.phase == PH_BACKOFF)
                begin
                    if (state_cur.retry_count < cfg.start_retries)
                    begin
                        if (!state_cur.armed)
                        begin
                            ns.armed = 1'b1;
                            ns.timer = 8'd0;
                        end
                        else
                        begin
                            ns.timer = bumped;
                            if (bumped >= BackoffDelay)
                            begin
                                ns.armed = 1'b0;
                                if (!state_cur.alive)
                                begin
                                    ns.alive   = 1'b1;
                                    ns.phase   = PH_STARTING;
                                    ns.timer   = 8'd0;
                                    launch_now = 1'b1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        ns.phase = PH_FATAL;
                        ns.armed = 1'b0;
                    end
                end
                else if (state_cur.phase == PH_STOPPING)
                begin
                    ns.timer = bumped;
                    if (bumped >= cfg.stop_wait)
                    begin
                        ns.phase = PH_STOPPED;
                        kill_now = state_cur.alive;
                    end
                end
                else if (state_cur.phase == PH_STOPPED && state_cur.pending &&
                         !state_cur.alive)
                begin
                    ns.pending = 1'b0;
                    ns.alive   = 1'b1;
                    ns.phase   = PH_STARTING;
                    ns.timer   = 8'd0;
                    launch_now = 1'b1;
                end
            end
            OP_EXIT:
            begin
                if (state_cur.alive)
                begin
                    ns.alive = 1'b0;
                    if (state_cur.phase == PH_STARTING)
                    begin
                        ns.phase = PH_BACKOFF;
                        ns.armed = 1'b0;
                        if (state_cur.retry_count != 8'hFF)
                        begin
                            ns.retry_count = state_cur.retry_count + 8'd1;
                        end
                    end
                    else if (state_cur.phase == PH_RUNNING)
                    begin
                        if (mode == MODE_ALWAYS ||
                            (mode == MODE_UNEXPECTED && !accepted))
                        begin
                            ns.alive   = 1'b1;
                            ns.phase   = PH_STARTING;
                            ns.timer   = 8'd0;
                            launch_now = 1'b1;
                        end
                        else
                        begin
                            ns.phase = PH_EXITED;
                        end
                    end
                    else if (state_cur.phase == PH_STOPPING)
                    begin
                        ns.phase = PH_STOPPED;
                    end
                end
            end
            OP_KILL:
            begin
                if (state_cur.alive)
                begin
                    ns.alive = 1'b0;
                    ns.phase = (state_cur.phase == PH_STOPPING) ? PH_STOPPED : PH_EXITED;
                end
            end
            OP_STOP, OP_RESTART:
            begin
                if (op == OP_RESTART)
                begin
                    ns.pending = 1'b1;
                end
                if (state_cur.phase != PH_STOPPING && state_cur.phase != PH_STOPPED)
                begin
                    ns.armed = 1'b0;
                    ns.timer = 8'd0;
                    ns.phase = state_cur.alive ? PH_STOPPING : PH_STOPPED;
                end
            end
            default:
            begin
                ns = state_cur;
            end
        endcase
    end

    assign state_new           = ns;
    assign result.phase        = ns.phase;
    assign result.launch       = launch_now;
    assign result.kill         = kill_now;
    assign result.retries_used = ns.retry_count;

endmodule

// ===== hw/rtl/child_restart_supervisor.sv =====
// Top level of the child restart supervisor with its register port and result register.
// Latency: the result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the single result register is refilled in the
// cycle it is taken, so the input stalls only while a result waits unaccepted.
// Reset: rst_n clears the supervisor state and the output valid flag and loads
// the register defaults; no item is refused after reset.
module child_restart_supervisor
    import crs_pkg::*;
#(
    parameter int BACKOFF_DELAY = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  exit_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  phase,
    output logic        launch,
    output logic        kill,
    output logic [7:0]  retries_used
);

    crs_cfg_t    cfg_reg;
    crs_state_t  state_reg;
    crs_state_t  state_next;
    crs_result_t result_next;
    crs_result_t result_reg;
    logic        out_valid_reg;
    logic        accept;
    logic        cfg_write;
    logic [2:0]  reg_index;

    assign pready    = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[5:3];

    crs_step #(
        .BACKOFF_DELAY(BACKOFF_DELAY)
    ) u_step (
        .state_cur(state_reg),
        .cfg(cfg_reg),
        .op(op),
        .exit_code(exit_code),
        .state_new(state_next),
        .result(result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_policy  <= 3'd0;
            cfg_reg.start_retries <= 8'd3;
            cfg_reg.start_wait    <= 8'd1;
            cfg_reg.stop_wait     <= 8'd10;
            cfg_reg.codes         <= {64'd0, 64'd0, 64'd0, 64'd1};
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_START_POLICY:  cfg_reg.start_policy  <= pwdata[2:0];
                REG_START_RETRIES: cfg_reg.start_retries <= pwdata[7:0];
                REG_START_WAIT:    cfg_reg.start_wait    <= pwdata[7:0];
                REG_STOP_WAIT:     cfg_reg.stop_wait     <= pwdata[7:0];
                REG_CODES_A:       cfg_reg.codes[0]      <= pwdata;
                REG_CODES_B:       cfg_reg.codes[1]      <= pwdata;
                REG_CODES_C:       cfg_reg.codes[2]      <= pwdata;
                REG_CODES_D:       cfg_reg.codes[3]      <= pwdata;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_START_POLICY:  prdata = {61'd0, cfg_reg.start_policy};
            REG_START_RETRIES: prdata = {56'd0, cfg_reg.start_retries};
            REG_START_WAIT:    prdata = {56'd0, cfg_reg.start_wait};
            REG_STOP_WAIT:     prdata = {56'd0, cfg_reg.stop_wait};
            REG_CODES_A:       prdata = cfg_reg.codes[0];
            REG_CODES_B:       prdata = cfg_reg.codes[1];
            REG_CODES_C:       prdata = cfg_reg.codes[2];
            REG_CODES_D:       prdata = cfg_reg.codes[3];
            default:           prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign phase        = result_reg.phase;
    assign launch       = result_reg.launch;
    assign kill         = result_reg.kill;
    assign retries_used = result_reg.retries_used;

endmodule

// ===== bench/crs_checker.sv =====
`timescale 1ns / 1ps
// Checker for the child restart supervisor: follows register writes, predicts each result, compares.
module crs_checker
    import crs_pkg::*;
#(
    parameter int BACKOFF_DELAY = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  op,
    input  logic [7:0]  exit_code,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  phase,
    input  logic        launch,
    input  logic        kill,
    input  logic [7:0]  retries_used,
    output int          fail_count,
    output int          pending_results
);

    crs_state_t  sup;
    crs_cfg_t    regs;
    crs_result_t due_results[$];
    crs_result_t want;

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic start_worker();
        if (sup.alive)
            return 1'b0;
        sup.alive = 1'b1;
        sup.phase = PH_STARTING;
        sup.timer = 8'd0;
        return 1'b1;
    endfunction

    function automatic void bump_timer();
        if (sup.timer != 8'hFF)
            sup.timer = sup.timer + 8'd1;
    endfunction

    function automatic void request_stop();
        if (sup.phase == PH_STOPPING || sup.phase == PH_STOPPED)
            return;
        sup.armed = 1'b0;
        sup.timer = 8'd0;
        sup.phase = sup.alive ? PH_STOPPING : PH_STOPPED;
    endfunction

    function automatic crs_result_t advance_supervisor(logic [2:0] cmd, logic [7:0] code);
        crs_result_t res;
        logic        go;
        logic        hard;
        go   = 1'b0;
        hard = 1'b0;
        case (cmd)
            OP_TICK:
            begin
                if ((sup.phase == PH_NOT_STARTED && regs.start_policy[0]) ||
                    (sup.phase == PH_EXITED && regs.start_policy[2:1] == MODE_ALWAYS))
                begin
                    go = start_worker();
                end
                else if (sup.phase == PH_STARTING)
                begin
                    bump_timer();
                    if (regs.start_wait == 8'd0 || sup.timer >= regs.start_wait)
                    begin
                        sup.phase       = PH_RUNNING;
                        sup.retry_count = 8'd0;
                    end
                end
                else if (sup.phase == PH_BACKOFF)
                begin
                    if (sup.retry_count < regs.start_retries)
                    begin
                        if (!sup.armed)
                        begin
                            sup.armed = 1'b1;
                            sup.timer = 8'd0;
                        end
                        else
                        begin
                            bump_timer();
                            if (sup.timer >= BACKOFF_DELAY)
                            begin
                                sup.armed = 1'b0;
                                go = start_worker();
                            end
                        end
                    end
                    else
                    begin
                        sup.phase = PH_FATAL;
                        sup.armed = 1'b0;
                    end
                end
                else if (sup.phase == PH_STOPPING)
                begin
                    bump_timer();
                    if (sup.timer >= regs.stop_wait)
                    begin
                        sup.phase = PH_STOPPED;
                        hard = sup.alive;
                    end
                end
                else if (sup.phase == PH_STOPPED && sup.pending && !sup.alive)
                begin
                    sup.pending = 1'b0;
                    go = start_worker();
                end
            end
            OP_EXIT:
            begin
                if (sup.alive)
                begin
                    sup.alive = 1'b0;
                    if (sup.phase == PH_STARTING)
                    begin
                        sup.phase = PH_BACKOFF;
                        sup.armed = 1'b0;
                        if (sup.retry_count != 8'hFF)
                            sup.retry_count = sup.retry_count + 8'd1;
                    end
                    else if (sup.phase == PH_RUNNING)
                    begin
                        if (regs.start_policy[2:1] == MODE_ALWAYS)
                        begin
                            go = start_worker();
                        end
                        else
                        begin
                            sup.phase = PH_EXITED;
                            if (regs.start_policy[2:1] == MODE_UNEXPECTED &&
                                !regs.codes[code[7:6]][code[5:0]])
                                go = start_worker();
                        end
                    end
                    else if (sup.phase == PH_STOPPING)
                    begin
                        sup.phase = PH_STOPPED;
                    end
                end
            end
            OP_KILL:
            begin
                if (sup.alive)
                begin
                    sup.alive = 1'b0;
                    sup.phase = (sup.phase == PH_STOPPING) ? PH_STOPPED : PH_EXITED;
                end
            end
            OP_STOP:
            begin
                request_stop();
            end
            OP_RESTART:
            begin
                sup.pending = 1'b1;
                request_stop();
            end
            default:
            begin
            end
        endcase
        res.phase        = sup.phase;
        res.launch       = go;
        res.kill         = hard;
        res.retries_used = sup.retry_count;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sup                = '0;
            regs.start_policy  = 3'd0;
            regs.start_retries = 8'd3;
            regs.start_wait    = 8'd1;
            regs.stop_wait     = 8'd10;
            regs.codes[0]      = 64'd1;
            regs.codes[1]      = 64'd0;
            regs.codes[2]      = 64'd0;
            regs.codes[3]      = 64'd0;
            due_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_START_POLICY:  regs.start_policy  = pwdata[2:0];
                    REG_START_RETRIES: regs.start_retries = pwdata[7:0];
                    REG_START_WAIT:    regs.start_wait    = pwdata[7:0];
                    REG_STOP_WAIT:     regs.stop_wait     = pwdata[7:0];
                    REG_CODES_A:       regs.codes[0]      = pwdata;
                    REG_CODES_B:       regs.codes[1]      = pwdata;
                    REG_CODES_C:       regs.codes[2]      = pwdata;
                    REG_CODES_D:       regs.codes[3]      = pwdata;
                    default:           ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with phase %0d but no item waiting", phase));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (phase !== want.phase)
                        report_mismatch($sformatf("phase %0d, expected %0d", phase, want.phase));
                    if (launch !== want.launch)
                        report_mismatch($sformatf("launch %0b, expected %0b", launch, want.launch));
                    if (kill !== want.kill)
                        report_mismatch($sformatf("kill %0b, expected %0b", kill, want.kill));
                    if (retries_used !== want.retries_used)
                        report_mismatch($sformatf("retries_used %0d, expected %0d",
                                                  retries_used, want.retries_used));
                end
            end
            if (in_valid && in_ready)
                due_results.push_back(advance_supervisor(op, exit_code));
            pending_results <= due_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the supervisor testbench: clock, reset, register writes, item stimulus and verdict.
module testbench
    import crs_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic [7:0]  exit_code;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  phase;
    logic        launch;
    logic        kill;
    logic [7:0]  retries_used;

    int fail_count;
    int pending_results;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_request = 0;

    child_restart_supervisor #(.BACKOFF_DELAY(5)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .exit_code    (exit_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .phase        (phase),
        .launch       (launch),
        .kill         (kill),
        .retries_used (retries_used)
    );

    crs_checker #(.BACKOFF_DELAY(5)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .exit_code       (exit_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .phase           (phase),
        .launch          (launch),
        .kill            (kill),
        .retries_used    (retries_used),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver stalls in random bursts, or for a long stretch when one is requested.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(logic [2:0] cmd, logic [7:0] code);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= cmd;
        exit_code <= code;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [63:0] with_noise(logic [7:0] value);
        logic [63:0] word;
        word = {$urandom, $urandom};
        word[7:0] = value;
        return word;
    endfunction

    function automatic logic [7:0] pick_wait();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'hFF;
        if (r == 1)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 4));
    endfunction

    function automatic logic [63:0] pick_codes();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 64'd0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic randomize_regs();
        write_reg(REG_START_POLICY, with_noise(8'($urandom_range(0, 7))));
        write_reg(REG_START_RETRIES,
                  with_noise(($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 3))));
        write_reg(REG_START_WAIT, with_noise(pick_wait()));
        write_reg(REG_STOP_WAIT, with_noise(pick_wait()));
        write_reg(REG_CODES_A, pick_codes());
        write_reg(REG_CODES_B, pick_codes());
        write_reg(REG_CODES_C, pick_codes());
        write_reg(REG_CODES_D, pick_codes());
    endtask

    task automatic random_item();
        int         r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 52)
            cmd = OP_TICK;
        else if (r < 70)
            cmd = OP_EXIT;
        else if (r < 79)
            cmd = OP_KILL;
        else if (r < 87)
            cmd = OP_STOP;
        else if (r < 96)
            cmd = OP_RESTART;
        else
            cmd = OP_RESTART + 3'($urandom_range(1, 3));
        send_item(cmd, 8'($urandom));
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        op        <= OP_TICK;
        exit_code <= 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: no autostart, restart mode never.
        send_item(OP_TICK, 8'h00);
        send_item(OP_EXIT, 8'hFF);
        send_item(OP_KILL, 8'h00);
        send_item(OP_RESTART + 3'd3, 8'h5A);
        send_item(OP_STOP, 8'h00);
        send_item(OP_RESTART, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_EXIT, 8'h00);
        drain_results();

        // Autostart with the unexpected mode; only exit code 255 is accepted.
        write_reg(REG_START_POLICY, 64'(3'd1 | (MODE_UNEXPECTED << 1)));
        write_reg(REG_START_RETRIES, 64'd1);
        write_reg(REG_START_WAIT, 64'd0);
        write_reg(REG_STOP_WAIT, 64'd0);
        write_reg(REG_CODES_A, 64'd0);
        write_reg(REG_CODES_B, 64'd0);
        write_reg(REG_CODES_C, 64'd0);
        write_reg(REG_CODES_D, 64'h8000_0000_0000_0000);
        send_item(OP_RESTART, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_EXIT, 8'hFF);
        send_item(OP_RESTART, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_EXIT, 8'h00);
        send_item(OP_EXIT, 8'h03);
        send_item(OP_TICK, 8'h00);
        drain_results();

        // Always restart with the widest start wait and retries; the hard kill leaves the worker alive.
        write_reg(REG_START_POLICY, 64'(3'd1 | (MODE_ALWAYS << 1)));
        write_reg(REG_START_RETRIES, 64'hFF);
        write_reg(REG_START_WAIT, 64'hFF);
        write_reg(REG_STOP_WAIT, 64'd1);
        write_reg(REG_CODES_A, '1);
        send_item(OP_RESTART, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_STOP, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_EXIT, 8'h05);
        send_item(OP_TICK, 8'h00);
        drain_results();

        for (int ph = 0; ph < 8; ph++)
        begin
            randomize_regs();
            tx_idle_on = (ph < 6);
            rx_idle_on = (ph < 6);
            if (ph == 2)
                hold_request = 300;
            for (int n = 0; n < 92; n++)
            begin
                random_item();
                if (ph == 3 && n == 45)
                    drain_results();
            end
            drain_results();
        end

        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
